// ===== sv/asr_pkg.sv =====
// ----------------------------------------------------------------------------
// asr_pkg
// Shared types and constants for the answer-submit request parser: parse
// phases, field tags, character codes, result-word widths and default limits.
// ----------------------------------------------------------------------------
package asr_pkg;

    // Default limits
    localparam int unsigned USER_ID_LEN_DEF  = 5;
    localparam int unsigned TOPIC_MAX_DEF    = 10;
    localparam int unsigned QUESTION_MAX_DEF = 10;
    localparam int unsigned TEXT_MAX_DEF     = 65536;
    localparam int unsigned EXT_MAX_DEF      = 3;
    localparam int unsigned IMAGE_MAX_DEF    = 1048576;

    // Fixed widths of the result word
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned FID_W       = 3;
    localparam int unsigned TEXT_LEN_W  = 17;
    localparam int unsigned IMAGE_LEN_W = 21;

    // Field tags
    localparam logic [FID_W-1:0] FID_NONE     = 3'd0;
    localparam logic [FID_W-1:0] FID_UID      = 3'd1;
    localparam logic [FID_W-1:0] FID_TOPIC    = 3'd2;
    localparam logic [FID_W-1:0] FID_QUESTION = 3'd3;
    localparam logic [FID_W-1:0] FID_TEXT     = 3'd4;
    localparam logic [FID_W-1:0] FID_EXT      = 3'd5;
    localparam logic [FID_W-1:0] FID_IMAGE    = 3'd6;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_ONE   = 8'h31;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;

    // Number of command bytes skipped at the head of a request
    localparam int unsigned CMD_LEN = 3;

    // Parse phases
    typedef enum logic [13:0] {
        PH_CMD   = 14'b00000000000001,
        PH_CSEP  = 14'b00000000000010,
        PH_UID   = 14'b00000000000100,
        PH_TOPIC = 14'b00000000001000,
        PH_QUEST = 14'b00000000010000,
        PH_TLEN  = 14'b00000000100000,
        PH_TEXT  = 14'b00000001000000,
        PH_TSEP  = 14'b00000010000000,
        PH_FLAG  = 14'b00000100000000,
        PH_FSEP  = 14'b00001000000000,
        PH_EXT   = 14'b00010000000000,
        PH_ILEN  = 14'b00100000000000,
        PH_IMG   = 14'b01000000000000,
        PH_END   = 14'b10000000000000
    } phase_t;

endpackage

// ===== sv/asr_if.sv =====
// ----------------------------------------------------------------------------
// asr_if
// Valid/ready channels of the request parser: request bytes in, tagged
// content and verdict words out.
// ----------------------------------------------------------------------------
interface asr_req_if;
    logic                           valid;
    logic                           ready;
    logic [asr_pkg::BYTE_W-1:0]     byte_in;
    logic                           last;

    modport source (output valid, output byte_in, output last, input ready);
    modport sink   (input valid, input byte_in, input last, output ready);
endinterface

interface asr_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [asr_pkg::FID_W-1:0]          field_id;
    logic [asr_pkg::BYTE_W-1:0]         data_byte;
    logic                               byte_valid;
    logic                               done_res;
    logic                               status;
    logic                               has_image;
    logic [asr_pkg::TEXT_LEN_W-1:0]     text_length;
    logic [asr_pkg::IMAGE_LEN_W-1:0]    image_length;

    modport source (output valid, output field_id, output data_byte, output byte_valid,
                    output done_res, output status, output has_image,
                    output text_length, output image_length, input ready);
    modport sink   (input valid, input field_id, input data_byte, input byte_valid,
                    input done_res, input status, input has_image,
                    input text_length, input image_length, output ready);
endinterface

// ===== sv/answer_submit_request_parser.sv =====
// ----------------------------------------------------------------------------
// answer_submit_request_parser
// Checks an answer-submit request one byte per word, passes content bytes out
// tagged by field and gives one success / bad-input verdict per request.
// ----------------------------------------------------------------------------
// A result word is registered and presented in the cycle after its byte.
// Throughput: 1 byte per cycle unless a full output register waits on rsp.ready;
//   the phase update and the length digit step (times ten, add, compare to the limit) are combinational.
// Bytes that give no result (command, separators, length digits, drained
//   bytes) never occupy the output register.
// Reset: rst_n clears parse state to the command phase and empties the
//   output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module answer_submit_request_parser #(
    parameter int unsigned USER_ID_LEN  = asr_pkg::USER_ID_LEN_DEF,
    parameter int unsigned TOPIC_MAX    = asr_pkg::TOPIC_MAX_DEF,
    parameter int unsigned QUESTION_MAX = asr_pkg::QUESTION_MAX_DEF,
    parameter int unsigned TEXT_MAX     = asr_pkg::TEXT_MAX_DEF,
    parameter int unsigned EXT_MAX      = asr_pkg::EXT_MAX_DEF,
    parameter int unsigned IMAGE_MAX    = asr_pkg::IMAGE_MAX_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    asr_req_if.sink       req,
    asr_rsp_if.source     rsp
);

    // Length accumulators hold up to the limit plus one (saturated overflow).
    localparam int unsigned TLEN_W = $clog2(TEXT_MAX + 2);
    localparam int unsigned ILEN_W = $clog2(IMAGE_MAX + 2);
    // Field counter covers the longest field: image, text, or a name field.
    localparam int unsigned CNT_A   = (TEXT_MAX > IMAGE_MAX) ? TEXT_MAX : IMAGE_MAX;
    localparam int unsigned CNT_MAX = (CNT_A > 64) ? CNT_A : 64;
    localparam int unsigned CNT_W   = $clog2(CNT_MAX + 1);

    // ------------------------------------------------------------------
    // Parse state
    // ------------------------------------------------------------------
    asr_pkg::phase_t        phase_reg, phase_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [TLEN_W-1:0]      tlen_reg, tlen_next;
    logic [ILEN_W-1:0]      ilen_reg, ilen_next;
    logic                   img_reg, img_next;
    logic                   drain_reg, drain_next;

    // Output register
    logic                               out_valid_reg;
    logic [asr_pkg::FID_W-1:0]          fid_reg;
    logic [asr_pkg::BYTE_W-1:0]         data_reg;
    logic                               bvalid_reg;
    logic                               done_reg;
    logic                               status_reg;
    logic                               himg_reg;
    logic [asr_pkg::TEXT_LEN_W-1:0]     tlen_out_reg;
    logic [asr_pkg::IMAGE_LEN_W-1:0]    ilen_out_reg;

    // Per-byte decode
    logic                       accept;
    logic                       out_load;
    logic                       emit;
    logic [asr_pkg::FID_W-1:0]  fid;
    logic                       ok;
    logic                       bad;
    logic                       verdict;
    logic                       restart;
    logic                       is_space;
    logic                       is_nl;
    logic                       is_digit;
    logic [3:0]                 digit;
    logic [CNT_W-1:0]           cnt_inc;
    logic [TLEN_W+3:0]          tprod;
    logic [ILEN_W+3:0]          iprod;
    logic [CNT_W-1:0]           name_max;
    asr_pkg::phase_t            name_nxt;
    logic [asr_pkg::FID_W-1:0]  name_fid;
    asr_pkg::phase_t            sep_nxt;

    // Take a byte whenever the output register is free or being drained.
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign is_space = (req.byte_in == asr_pkg::CH_SPACE);
    assign is_nl    = (req.byte_in == asr_pkg::CH_NL);
    assign is_digit = (req.byte_in >= asr_pkg::CH_ZERO) && (req.byte_in <= asr_pkg::CH_NINE);
    assign digit    = req.byte_in[3:0];
    assign cnt_inc  = cnt_reg + CNT_W'(1);

    // Decimal length step: acc * 10 + digit
    assign tprod = (TLEN_W+4)'({tlen_reg, 3'b000}) + (TLEN_W+4)'({tlen_reg, 1'b0})
                 + (TLEN_W+4)'(digit);
    assign iprod = (ILEN_W+4)'({ilen_reg, 3'b000}) + (ILEN_W+4)'({ilen_reg, 1'b0})
                 + (ILEN_W+4)'(digit);

    // Limits and successors of the space-free name fields
    always_comb
    begin
        name_max = CNT_W'(EXT_MAX);
        name_nxt = asr_pkg::PH_ILEN;
        name_fid = asr_pkg::FID_EXT;
        if (phase_reg == asr_pkg::PH_TOPIC)
        begin
            name_max = CNT_W'(TOPIC_MAX);
            name_nxt = asr_pkg::PH_QUEST;
            name_fid = asr_pkg::FID_TOPIC;
        end
        else if (phase_reg == asr_pkg::PH_QUEST)
        begin
            name_max = CNT_W'(QUESTION_MAX);
            name_nxt = asr_pkg::PH_TLEN;
            name_fid = asr_pkg::FID_QUESTION;
        end
    end

    // Successors of the single-space separators
    always_comb
    begin
        sep_nxt = asr_pkg::PH_EXT;
        if (phase_reg == asr_pkg::PH_CSEP)
            sep_nxt = asr_pkg::PH_UID;
        else if (phase_reg == asr_pkg::PH_TSEP)
            sep_nxt = asr_pkg::PH_FLAG;
    end

    // ------------------------------------------------------------------
    // Phase step for one byte
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        tlen_next  = tlen_reg;
        ilen_next  = ilen_reg;
        img_next   = img_reg;
        drain_next = drain_reg;
        emit       = 1'b0;
        fid        = asr_pkg::FID_NONE;
        ok         = 1'b0;
        bad        = 1'b0;
        verdict    = 1'b0;
        restart    = 1'b0;

        if (drain_reg)
        begin
            // Drop the rest of a rejected request up to its last byte.
            restart = req.last;
        end
        else
        begin
            unique case (phase_reg) inside
                asr_pkg::PH_CMD:
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= CNT_W'(asr_pkg::CMD_LEN))
                    begin
                        phase_next = asr_pkg::PH_CSEP;
                        cnt_next   = '0;
                    end
                end
                asr_pkg::PH_CSEP, asr_pkg::PH_TSEP, asr_pkg::PH_FSEP:
                begin
                    if (!is_space)
                        bad = 1'b1;
                    else
                    begin
                        phase_next = sep_nxt;
                        cnt_next   = '0;
                    end
                end
                asr_pkg::PH_UID:
                begin
                    if (is_space && cnt_reg != '0)
                    begin
                        phase_next = asr_pkg::PH_TOPIC;
                        cnt_next   = '0;
                    end
                    else if (is_digit && cnt_reg < CNT_W'(USER_ID_LEN))
                    begin
                        cnt_next = cnt_inc;
                        emit     = 1'b1;
                        fid      = asr_pkg::FID_UID;
                    end
                    else
                        bad = 1'b1;
                end
                asr_pkg::PH_TOPIC, asr_pkg::PH_QUEST, asr_pkg::PH_EXT:
                begin
                    if (is_space)
                    begin
                        if (cnt_reg == '0)
                            bad = 1'b1;
                        else
                        begin
                            phase_next = name_nxt;
                            cnt_next   = '0;
                        end
                    end
                    else if (is_nl || cnt_reg >= name_max)
                        bad = 1'b1;
                    else
                    begin
                        cnt_next = cnt_inc;
                        emit     = 1'b1;
                        fid      = name_fid;
                    end
                end
                asr_pkg::PH_TLEN:
                begin
                    if (is_digit)
                    begin
                        if (tprod > (TLEN_W+4)'(TEXT_MAX))
                        begin
                            tlen_next = TLEN_W'(TEXT_MAX + 1);
                            bad       = 1'b1;
                        end
                        else
                            tlen_next = tprod[TLEN_W-1:0];
                    end
                    else if (is_space && tlen_reg != '0)
                    begin
                        phase_next = asr_pkg::PH_TEXT;
                        cnt_next   = '0;
                    end
                    else
                        bad = 1'b1;
                end
                asr_pkg::PH_TEXT:
                begin
                    cnt_next = cnt_inc;
                    emit     = 1'b1;
                    fid      = asr_pkg::FID_TEXT;
                    if (cnt_inc >= CNT_W'(tlen_reg))
                    begin
                        phase_next = asr_pkg::PH_TSEP;
                        cnt_next   = '0;
                    end
                end
                asr_pkg::PH_FLAG:
                begin
                    if (req.byte_in == asr_pkg::CH_ONE)
                    begin
                        img_next   = 1'b1;
                        phase_next = asr_pkg::PH_FSEP;
                        cnt_next   = '0;
                    end
                    else if (req.byte_in == asr_pkg::CH_ZERO)
                    begin
                        phase_next = asr_pkg::PH_END;
                        cnt_next   = '0;
                    end
                    else
                        bad = 1'b1;
                end
                asr_pkg::PH_ILEN:
                begin
                    if (is_digit)
                    begin
                        if (iprod > (ILEN_W+4)'(IMAGE_MAX))
                        begin
                            ilen_next = ILEN_W'(IMAGE_MAX + 1);
                            bad       = 1'b1;
                        end
                        else
                            ilen_next = iprod[ILEN_W-1:0];
                    end
                    else if (is_space && ilen_reg != '0)
                    begin
                        phase_next = asr_pkg::PH_IMG;
                        cnt_next   = '0;
                    end
                    else
                        bad = 1'b1;
                end
                asr_pkg::PH_IMG:
                begin
                    cnt_next = cnt_inc;
                    emit     = 1'b1;
                    fid      = asr_pkg::FID_IMAGE;
                    if (cnt_inc >= CNT_W'(ilen_reg))
                    begin
                        phase_next = asr_pkg::PH_END;
                        cnt_next   = '0;
                    end
                end
                asr_pkg::PH_END:
                begin
                    // Terminator must be a newline carried on the last byte.
                    if (is_nl && req.last)
                        ok = 1'b1;
                    else
                        bad = 1'b1;
                end
                default:
                    bad = 1'b1;
            endcase

            // Early last: request ends before the terminator.
            if (!ok && !bad && req.last)
                bad = 1'b1;

            verdict = ok || bad;
            if (verdict)
            begin
                restart    = req.last;
                drain_next = !req.last;
            end
        end
    end

    assign out_load = accept && (emit || verdict);

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= asr_pkg::PH_CMD;
            cnt_reg   <= '0;
            tlen_reg  <= '0;
            ilen_reg  <= '0;
            img_reg   <= 1'b0;
            drain_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (restart)
            begin
                // Start a fresh request.
                phase_reg <= asr_pkg::PH_CMD;
                cnt_reg   <= '0;
                tlen_reg  <= '0;
                ilen_reg  <= '0;
                img_reg   <= 1'b0;
                drain_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                tlen_reg  <= tlen_next;
                ilen_reg  <= ilen_next;
                img_reg   <= img_next;
                drain_reg <= drain_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    // Verdict fields carry the lengths and flag as updated by this byte.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            fid_reg      <= emit ? fid : asr_pkg::FID_NONE;
            data_reg     <= emit ? req.byte_in : '0;
            bvalid_reg   <= emit;
            done_reg     <= verdict;
            status_reg   <= bad;
            himg_reg     <= verdict && img_next;
            tlen_out_reg <= verdict ? asr_pkg::TEXT_LEN_W'(tlen_next) : '0;
            ilen_out_reg <= verdict ? asr_pkg::IMAGE_LEN_W'(ilen_next) : '0;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.field_id     = fid_reg;
    assign rsp.data_byte    = data_reg;
    assign rsp.byte_valid   = bvalid_reg;
    assign rsp.done_res     = done_reg;
    assign rsp.status       = status_reg;
    assign rsp.has_image    = himg_reg;
    assign rsp.text_length  = tlen_out_reg;
    assign rsp.image_length = ilen_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Bytes of a rejected request never reach the output.
    a_drain_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && drain_reg) |-> !out_load)
        else $error("drained byte produced a result word");

    // A success verdict comes on the bare terminator, never with content.
    a_ok_no_content: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg && !status_reg) |-> !bvalid_reg)
        else $error("success verdict carries a content byte");

    // Content words are always tagged with a field.
    a_tagged: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && bvalid_reg) |-> (fid_reg != asr_pkg::FID_NONE))
        else $error("content byte without field tag");

    // A verdict without last leaves the parser draining.
    a_enter_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && verdict && !req.last) |=> drain_reg)
        else $error("rejected request not drained");

    // Accumulated text length never passes the limit plus one.
    a_tlen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (TLEN_W+1)'(tlen_reg) <= (TLEN_W+1)'(TEXT_MAX + 1))
        else $error("text length accumulator out of range");

endmodule
